// ===== hw/rtl/msad_pkg.sv =====
package msad_pkg;

  localparam int unsigned CodeW = 13;
  localparam int unsigned FeetW = 18;
  localparam int unsigned EncW  = 2;
  localparam int unsigned GrayW = 8;

  typedef logic [EncW-1:0] enc_t;

  localparam enc_t ENC_25FT    = 2'd0;
  localparam enc_t ENC_GILLHAM = 2'd1;
  localparam enc_t ENC_METRES  = 2'd2;

  localparam int unsigned MetresW    = 12;
  localparam int unsigned ProdW      = 34;
  localparam int unsigned MToFtShift = 20;
  localparam logic [ProdW-1:0] M_TO_FT_NUM = 34'd3440210;
  localparam logic [FeetW-1:0] METRES_FEET_MAX = 18'd13435;

  localparam logic signed [FeetW-1:0] STEP25_OFFSET  = 18'sd1000;
  localparam logic signed [FeetW-1:0] GILLHAM_OFFSET = -18'sd1200;

  function automatic logic [GrayW-1:0] gray_to_bin(input logic [GrayW-1:0] g);
    logic [GrayW-1:0] b;
    b[GrayW-1] = g[GrayW-1];
    for (int i = GrayW - 2; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/mode_s_altitude_decode_core.sv =====
// Decodes the 13-bit AC altitude field of a Mode S reply into feet and an
// encoding tag (25-foot steps, Gillham 100-foot steps, or metres converted).
// The block takes one transfer per clock cycle while out_ready does not hold
// a result back. Each item passes through the input register and then the
// result register, with the whole decode in the logic between them. While
// out_ready holds a result back, the input register waits behind it, and
// in_ready drops once both registers are full.
// Invalid Gillham patterns are not flagged and decode by the same arithmetic.
module mode_s_altitude_decode_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [msad_pkg::CodeW-1:0]             in_altitude_code,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [msad_pkg::FeetW-1:0]      out_altitude_feet,
  output logic [msad_pkg::EncW-1:0]              out_encoding
);

  logic                              s0_valid_r;
  logic [msad_pkg::CodeW-1:0]        code_r;
  logic                              out_valid_r;
  logic signed [msad_pkg::FeetW-1:0] feet_r;
  msad_pkg::enc_t                    enc_r;

  logic s1_load;

  assign s1_load  = !out_valid_r || out_ready;
  assign in_ready = !s0_valid_r || s1_load;

  logic [msad_pkg::MetresW-1:0]      metres;
  logic [msad_pkg::ProdW-1:0]        prod;
  logic [10:0]                       v;
  logic signed [msad_pkg::FeetW-1:0] feet_m;
  logic signed [msad_pkg::FeetW-1:0] feet_q;
  logic signed [msad_pkg::FeetW-1:0] feet_g;
  logic [msad_pkg::GrayW-1:0]        g500;
  logic [msad_pkg::GrayW-1:0]        n500;
  logic [msad_pkg::GrayW-1:0]        n100_bin;
  logic signed [3:0]                 n100_raw;
  logic signed [3:0]                 n100_fix;
  logic signed [3:0]                 n100;
  logic signed [msad_pkg::FeetW-1:0] feet_nxt;
  msad_pkg::enc_t                    enc_nxt;

  always_comb begin
    metres = {code_r[12:7], code_r[5:0]};
    prod   = {{(msad_pkg::ProdW - msad_pkg::MetresW){1'b0}}, metres} * msad_pkg::M_TO_FT_NUM;
    feet_m = $signed({4'b0, prod[msad_pkg::ProdW-1:msad_pkg::MToFtShift]});

    v      = {code_r[12:7], code_r[5], code_r[3:0]};
    feet_q = $signed({7'b0, v}) * 18'sd25 - msad_pkg::STEP25_OFFSET;

    g500     = {v[2], v[0], v[9], v[7], v[5], v[4], v[3], v[1]};
    n500     = msad_pkg::gray_to_bin(g500);
    n100_bin = msad_pkg::gray_to_bin({5'b0, v[10], v[8], v[6]});
    n100_raw = $signed({1'b0, n100_bin[2:0]}) - 4'sd1;
    n100_fix = (n100_raw == 4'sd6) ? 4'sd4 : n100_raw;
    n100     = n500[0] ? (4'sd4 - n100_fix) : n100_fix;
    feet_g   = msad_pkg::GILLHAM_OFFSET
             + $signed({10'b0, n500}) * 18'sd500
             + $signed({{14{n100[3]}}, n100}) * 18'sd100;

    if (code_r[6]) begin
      feet_nxt = feet_m;
      enc_nxt  = msad_pkg::ENC_METRES;
    end else if (code_r[4]) begin
      feet_nxt = feet_q;
      enc_nxt  = msad_pkg::ENC_25FT;
    end else begin
      feet_nxt = feet_g;
      enc_nxt  = msad_pkg::ENC_GILLHAM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_load) begin
        out_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_altitude_code;
    end
    if (s1_load && s0_valid_r) begin
      feet_r <= feet_nxt;
      enc_r  <= enc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_altitude_feet = feet_r;
  assign out_encoding      = enc_r;

  a_enc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (enc_r == msad_pkg::ENC_25FT || enc_r == msad_pkg::ENC_GILLHAM ||
                     enc_r == msad_pkg::ENC_METRES))
    else $error("result carries an undefined encoding tag");

  a_metres_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && enc_r == msad_pkg::ENC_METRES) |->
      (!feet_r[msad_pkg::FeetW-1] && $unsigned(feet_r) <= msad_pkg::METRES_FEET_MAX))
    else $error("metres conversion out of range");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && s1_load) |=> out_valid_r)
    else $error("item in the input register was lost");

endmodule
